/* hw/rtl/conv3x3_pkg.sv */
// ----------------------------------------------------------------------------
// conv3x3_pkg
// Shared constants, types and codes of the 3x3 convolution filter.
// ----------------------------------------------------------------------------
package conv3x3_pkg;

    localparam int MAX_WIDTH_DEF  = 512;
    localparam int FIFO_DEPTH_DEF = 4;
    localparam int MAX_HEIGHT     = 4096;

    localparam int PIX_W       = 8;
    localparam int WIDTH_W     = 10;
    localparam int HEIGHT_W    = 13;
    localparam int COUNT_W     = 22;
    localparam int FRAME_W     = WIDTH_W + HEIGHT_W;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int SUM_W       = 12;

    localparam logic [PIX_W-1:0]    PAD_PIXEL      = 8'd127;
    localparam int                  DEFAULT_WIDTH  = 256;
    localparam logic [HEIGHT_W-1:0] DEFAULT_HEIGHT = 13'd256;

    // floor(x / 9) == (x * 7282) >> 16 for every x below 32768.
    localparam int               RECIP_W    = 13;
    localparam logic [RECIP_W-1:0] DIV9_RECIP = 13'd7282;
    localparam int               DIV9_SHIFT = 16;

    localparam logic ACTION_PUSH  = 1'b0;
    localparam logic ACTION_FLUSH = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_KERNEL_MODE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_IMAGE_HEIGHT = 2'd2;

    typedef enum logic [1:0] {
        KERNEL_EMBOSS,
        KERNEL_BLUR,
        KERNEL_SMOOTH,
        KERNEL_SHARPEN
    } kernel_mode_t;

    // Classification of one step, made by the front end for the back end.
    typedef struct packed {
        logic col_first;
        logic row_ge1;
        logic row_ge2;
        logic emit;
        logic last;
    } op_ctrl_t;

endpackage

/* hw/rtl/conv3x3_ram.sv */
// ----------------------------------------------------------------------------
// conv3x3_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module conv3x3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/conv3x3_fifo.sv */
// ----------------------------------------------------------------------------
// conv3x3_fifo
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module conv3x3_fifo #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             wr_fire;
    logic             rd_fire;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign wr_fire  = wr_valid && wr_ready;
    assign rd_fire  = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_fire) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (rd_fire) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (wr_fire && !rd_fire) begin
            count_next = count_reg + CNT_W'(1);
        end else if (rd_fire && !wr_fire) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_fire) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count exceeds its depth");

endmodule

/* hw/rtl/conv3x3_front.sv */
// ----------------------------------------------------------------------------
// conv3x3_front
// Configuration registers, raster position tracking and request classification.
// ----------------------------------------------------------------------------
module conv3x3_front #(
    parameter int MAX_WIDTH = conv3x3_pkg::MAX_WIDTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_action,
    input  logic [conv3x3_pkg::PIX_W-1:0]         s_pixel_in,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [conv3x3_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [conv3x3_pkg::CFG_DATA_W-1:0]    cfg_data,
    output conv3x3_pkg::kernel_mode_t             kernel_mode,
    output logic                                  op_valid,
    input  logic                                  op_ready,
    output conv3x3_pkg::op_ctrl_t                 op_ctrl,
    output logic [$clog2(MAX_WIDTH)-1:0]          op_column,
    output logic [conv3x3_pkg::PIX_W-1:0]         op_pixel
);

    import conv3x3_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam logic [WIDTH_W-1:0] RESET_WIDTH =
        (DEFAULT_WIDTH > MAX_WIDTH) ? WIDTH_W'(MAX_WIDTH) : WIDTH_W'(DEFAULT_WIDTH);

    kernel_mode_t          kernel_mode_reg;
    logic [WIDTH_W-1:0]    width_reg;
    logic [HEIGHT_W-1:0]   height_reg;
    logic [COL_W-1:0]      col_reg, col_next;
    logic [HEIGHT_W-1:0]   row_reg, row_next;
    logic [COUNT_W-1:0]    count_reg, count_next;

    logic [WIDTH_W-1:0]    cfg_width;
    logic [HEIGHT_W-1:0]   cfg_height;
    logic                  restart;
    logic [FRAME_W-1:0]    frame_size;
    logic [FRAME_W-1:0]    count_inc;
    logic                  frame_done;
    logic                  all_in;
    logic                  item_fire;
    logic                  do_step;
    logic                  col_wrap;
    op_ctrl_t              ctrl;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_width = cfg_data[WIDTH_W-1:0];
        if (cfg_width == '0) begin
            cfg_width = WIDTH_W'(1);
        end else if (int'(cfg_width) > MAX_WIDTH) begin
            cfg_width = WIDTH_W'(MAX_WIDTH);
        end
        cfg_height = cfg_data[HEIGHT_W-1:0];
        if (cfg_height == '0) begin
            cfg_height = HEIGHT_W'(1);
        end else if (cfg_height > HEIGHT_W'(MAX_HEIGHT)) begin
            cfg_height = HEIGHT_W'(MAX_HEIGHT);
        end
    end

    assign restart = cfg_valid &&
        ((cfg_index == CFG_IDX_IMAGE_WIDTH) || (cfg_index == CFG_IDX_IMAGE_HEIGHT));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kernel_mode_reg <= KERNEL_EMBOSS;
            width_reg       <= RESET_WIDTH;
            height_reg      <= DEFAULT_HEIGHT;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_IDX_KERNEL_MODE:  kernel_mode_reg <= kernel_mode_t'(cfg_data[1:0]);
                CFG_IDX_IMAGE_WIDTH:  width_reg       <= cfg_width;
                CFG_IDX_IMAGE_HEIGHT: height_reg      <= cfg_height;
                default: ;
            endcase
        end
    end

    assign kernel_mode = kernel_mode_reg;

    // ---------------- classification ----------------
    assign frame_size = width_reg * height_reg;
    assign count_inc  = FRAME_W'(count_reg) + FRAME_W'(1);
    assign frame_done = FRAME_W'(count_reg) >= frame_size;
    assign all_in     = row_reg >= height_reg;
    assign item_fire  = s_valid && s_ready;

    // A push is dropped once all rows of the frame are in; a flush only counts then.
    assign do_step = item_fire &&
        ((s_action == ACTION_PUSH) ? !all_in : (all_in && !frame_done));

    assign col_wrap = (int'(col_reg) + 1) >= int'(width_reg);

    always_comb begin
        ctrl.col_first = (col_reg == '0);
        ctrl.row_ge1   = (row_reg != '0);
        ctrl.row_ge2   = (row_reg >= HEIGHT_W'(2));
        ctrl.emit      = ctrl.col_first ? ctrl.row_ge2 : ctrl.row_ge1;
        ctrl.last      = ctrl.emit && (count_inc >= frame_size);
    end

    always_comb begin
        col_next   = col_reg;
        row_next   = row_reg;
        count_next = count_reg;
        if (do_step) begin
            if (col_wrap) begin
                col_next = '0;
                row_next = row_reg + HEIGHT_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
            if (ctrl.emit) begin
                count_next = count_inc[COUNT_W-1:0];
            end
            if (ctrl.last) begin
                col_next   = '0;
                row_next   = '0;
                count_next = '0;
            end
        end
        if (restart) begin
            col_next   = '0;
            row_next   = '0;
            count_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            row_reg   <= '0;
            count_reg <= '0;
        end else begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            count_reg <= count_next;
        end
    end

    assign s_ready   = op_ready;
    assign op_valid  = do_step;
    assign op_ctrl   = ctrl;
    assign op_column = col_reg;
    assign op_pixel  = (s_action == ACTION_FLUSH) ? PAD_PIXEL : s_pixel_in;

    a_col_in_row: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(col_reg) < int'(width_reg))
        else $error("column position beyond the image width");

    a_count_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        FRAME_W'(count_reg) < frame_size)
        else $error("result count passed the frame size without a restart");

endmodule

/* hw/rtl/conv3x3_back.sv */
// ----------------------------------------------------------------------------
// conv3x3_back
// Line store, 3x3 window, kernel arithmetic and the output register.
// ----------------------------------------------------------------------------
module conv3x3_back #(
    parameter int MAX_WIDTH = conv3x3_pkg::MAX_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  conv3x3_pkg::kernel_mode_t     kernel_mode,
    input  logic                          op_valid,
    output logic                          op_ready,
    input  conv3x3_pkg::op_ctrl_t         op_ctrl,
    input  logic [$clog2(MAX_WIDTH)-1:0]  op_column,
    input  logic [conv3x3_pkg::PIX_W-1:0] op_pixel,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [conv3x3_pkg::PIX_W-1:0] m_pixel_out,
    output logic                          m_last_of_frame
);

    import conv3x3_pkg::*;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int LINE_W  = 2 * PIX_W;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam int EMB_W   = PIX_W + 2;
    localparam int SHARP_W = SUM_W + 1;

    logic adv;
    logic pop;

    // Read stage to window stage.
    logic              x_valid_reg;
    op_ctrl_t          x_ctrl_reg;
    logic [COL_W-1:0]  x_col_reg;
    logic [PIX_W-1:0]  x_pixel_reg;
    logic              x_fwd_reg;
    logic [LINE_W-1:0] x_fwd_data_reg;

    logic [LINE_W-1:0] ram_rd_data;
    logic [LINE_W-1:0] line_data;
    logic [LINE_W-1:0] line_wr_data;
    logic              fwd_hit;

    // Window: two stored columns, row 0 on top.
    logic [PIX_W-1:0] win_a_reg [3];
    logic [PIX_W-1:0] win_b_reg [3];
    logic [PIX_W-1:0] new_col [3];
    logic [PIX_W-1:0] k_col [3];

    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] wsum;

    // Sum stage.
    logic             s_valid_reg;
    logic             s_last_reg;
    logic [SUM_W-1:0] s_sum_reg;
    logic [SUM_W-1:0] s_wsum_reg;
    logic [PIX_W-1:0] s_tl_reg;
    logic [PIX_W-1:0] s_center_reg;
    logic [PIX_W-1:0] s_br_reg;

    // Output stage.
    logic             m_valid_reg;
    logic             m_last_reg;
    logic [PIX_W-1:0] m_pixel_reg;

    logic [PROD_W-1:0]  blur_prod;
    logic [EMB_W-1:0]   emboss_val;
    logic [SHARP_W-1:0] sharp_val;
    logic [PIX_W-1:0]   filt_pixel;

    // The whole back pipeline moves together; it halts only on a held result.
    assign adv      = !m_valid_reg || m_ready;
    assign pop      = adv && op_valid;
    assign op_ready = adv;

    // ---------------- line store ----------------
    // Each entry holds the pixel of the row above (low byte) and the row
    // above that (high byte) at one column.
    assign line_data    = x_fwd_reg ? x_fwd_data_reg : ram_rd_data;
    assign line_wr_data = {line_data[PIX_W-1:0], x_pixel_reg};

    // With a one-pixel row the next request reads the entry that is written
    // in the same cycle, so the written value is forwarded.
    assign fwd_hit = pop && x_valid_reg && (op_column == x_col_reg);

    conv3x3_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (adv && x_valid_reg),
        .wr_addr (x_col_reg),
        .wr_data (line_wr_data),
        .rd_en   (adv),
        .rd_addr (op_column),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_valid_reg <= 1'b0;
            x_fwd_reg   <= 1'b0;
        end else if (adv) begin
            x_valid_reg <= pop;
            x_fwd_reg   <= fwd_hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x_ctrl_reg     <= op_ctrl;
            x_col_reg      <= op_column;
            x_pixel_reg    <= op_pixel;
            x_fwd_data_reg <= line_wr_data;
        end
    end

    // ---------------- window ----------------
    always_comb begin
        new_col[0] = x_ctrl_reg.row_ge2 ? line_data[LINE_W-1:PIX_W] : PAD_PIXEL;
        new_col[1] = x_ctrl_reg.row_ge1 ? line_data[PIX_W-1:0] : PAD_PIXEL;
        new_col[2] = x_pixel_reg;
        // At the start of a row the kernel sees the finished previous row,
        // padded on the right.
        for (int r = 0; r < 3; r++) begin
            k_col[r] = x_ctrl_reg.col_first ? PAD_PIXEL : new_col[r];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < 3; r++) begin
                win_a_reg[r] <= PAD_PIXEL;
                win_b_reg[r] <= PAD_PIXEL;
            end
        end else if (adv && x_valid_reg) begin
            for (int r = 0; r < 3; r++) begin
                win_a_reg[r] <= x_ctrl_reg.col_first ? PAD_PIXEL : win_b_reg[r];
                win_b_reg[r] <= new_col[r];
            end
        end
    end

    assign sum = SUM_W'(win_a_reg[0]) + SUM_W'(win_b_reg[0]) + SUM_W'(k_col[0])
               + SUM_W'(win_a_reg[1]) + SUM_W'(win_b_reg[1]) + SUM_W'(k_col[1])
               + SUM_W'(win_a_reg[2]) + SUM_W'(win_b_reg[2]) + SUM_W'(k_col[2]);

    assign wsum = SUM_W'(win_a_reg[0]) + SUM_W'(k_col[0])
                + SUM_W'(win_a_reg[2]) + SUM_W'(k_col[2])
                + ((SUM_W'(win_b_reg[0]) + SUM_W'(win_a_reg[1])
                  + SUM_W'(k_col[1]) + SUM_W'(win_b_reg[2])) << 1)
                + (SUM_W'(win_b_reg[1]) << 2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s_valid_reg <= 1'b0;
        end else if (adv) begin
            s_valid_reg <= x_valid_reg && x_ctrl_reg.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s_last_reg   <= x_ctrl_reg.last;
            s_sum_reg    <= sum;
            s_wsum_reg   <= wsum;
            s_tl_reg     <= win_a_reg[0];
            s_center_reg <= win_b_reg[1];
            s_br_reg     <= k_col[2];
        end
    end

    // ---------------- kernel select and saturation ----------------
    assign blur_prod  = PROD_W'(s_sum_reg) * PROD_W'(DIV9_RECIP);
    assign emboss_val = EMB_W'(s_br_reg) + EMB_W'(PAD_PIXEL) - EMB_W'(s_tl_reg);
    assign sharp_val  = (SHARP_W'(s_center_reg) << 3) + (SHARP_W'(s_center_reg) << 1)
                      - SHARP_W'(s_sum_reg);

    always_comb begin
        case (kernel_mode)
            KERNEL_EMBOSS: begin
                if (emboss_val[EMB_W-1]) begin
                    filt_pixel = '0;
                end else if (emboss_val[EMB_W-2]) begin
                    filt_pixel = '1;
                end else begin
                    filt_pixel = emboss_val[PIX_W-1:0];
                end
            end
            KERNEL_BLUR: begin
                filt_pixel = blur_prod[DIV9_SHIFT +: PIX_W];
            end
            KERNEL_SMOOTH: begin
                filt_pixel = s_wsum_reg[SUM_W-1:4];
            end
            KERNEL_SHARPEN: begin
                if (sharp_val[SHARP_W-1]) begin
                    filt_pixel = '0;
                end else if (|sharp_val[SHARP_W-2:PIX_W]) begin
                    filt_pixel = '1;
                end else begin
                    filt_pixel = sharp_val[PIX_W-1:0];
                end
            end
            default: begin
                filt_pixel = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= s_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_pixel_reg <= filt_pixel;
            m_last_reg  <= s_last_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_pixel_out     = m_pixel_reg;
    assign m_last_of_frame = m_last_reg;

    a_fwd_has_request: assert property (@(posedge aclk) disable iff (!aresetn)
        x_fwd_reg |-> x_valid_reg)
        else $error("line store forwarding armed without a request in the window stage");

endmodule

/* hw/rtl/conv3x3_emboss_blur_sharpen.sv */
// ----------------------------------------------------------------------------
// conv3x3_emboss_blur_sharpen
// 3x3 convolution filter for 8-bit gray images in raster order. Pixels that
// lie outside the image count as 127. Kernel mode 0 is emboss, 1 box blur
// (sum / 9), 2 smoothing (1-2-1 weights, sum / 16) and 3 sharpen; results
// saturate to 0..255. While results are taken, the block sustains one request
// per clock: the front end classifies a request in the cycle it is taken, and
// the back end does one read and one write of the single-port-per-direction
// line store per request, so no resource is shared across requests. A result
// appears image_width + 1 requests behind its pixel, and the last image_width
// + 1 results of a frame are drained by flush requests; from acceptance a
// request passes the queue, then the read, sum and output stage registers.
// The line store needs no clearing after reset, so requests are taken at once.
// ----------------------------------------------------------------------------
module conv3x3_emboss_blur_sharpen #(
    parameter int MAX_WIDTH  = conv3x3_pkg::MAX_WIDTH_DEF,
    parameter int FIFO_DEPTH = conv3x3_pkg::FIFO_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_action,
    input  logic [conv3x3_pkg::PIX_W-1:0]       s_pixel_in,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [conv3x3_pkg::PIX_W-1:0]       m_pixel_out,
    output logic                                m_last_of_frame,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [conv3x3_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [conv3x3_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import conv3x3_pkg::*;

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int CTRL_W   = $bits(op_ctrl_t);
    localparam int QUEUE_W  = COL_W + PIX_W + CTRL_W;

    kernel_mode_t      kernel_mode;
    logic              f_valid;
    logic              f_ready;
    op_ctrl_t          f_ctrl;
    logic [COL_W-1:0]  f_column;
    logic [PIX_W-1:0]  f_pixel;
    logic [QUEUE_W-1:0] q_wr_data;
    logic [QUEUE_W-1:0] q_rd_data;
    logic              b_valid;
    logic              b_ready;
    op_ctrl_t          b_ctrl;
    logic [COL_W-1:0]  b_column;
    logic [PIX_W-1:0]  b_pixel;

    conv3x3_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_pixel_in  (s_pixel_in),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .kernel_mode (kernel_mode),
        .op_valid    (f_valid),
        .op_ready    (f_ready),
        .op_ctrl     (f_ctrl),
        .op_column   (f_column),
        .op_pixel    (f_pixel)
    );

    assign q_wr_data = {f_column, f_pixel, f_ctrl};

    conv3x3_fifo #(
        .WIDTH (QUEUE_W),
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (q_wr_data),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_data  (q_rd_data)
    );

    assign b_ctrl   = op_ctrl_t'(q_rd_data[CTRL_W-1:0]);
    assign b_pixel  = q_rd_data[CTRL_W +: PIX_W];
    assign b_column = q_rd_data[CTRL_W + PIX_W +: COL_W];

    conv3x3_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .kernel_mode     (kernel_mode),
        .op_valid        (b_valid),
        .op_ready        (b_ready),
        .op_ctrl         (b_ctrl),
        .op_column       (b_column),
        .op_pixel        (b_pixel),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_out     (m_pixel_out),
        .m_last_of_frame (m_last_of_frame)
    );

endmodule
